// ===== design/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg : shared types, codes and helpers of the integer to ASCII converter
// Format codes, sequencer states, the digit glyph tables and the helpers of
// the shift-and-add-3 unit and of the leading digit search.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int NDIGITS  = 10;                  // decimal digits of a 32-bit value
  localparam int BCD_W    = NDIGITS * DIGIT_W;
  localparam int IDX_W    = 4;                   // digit index 0 .. NDIGITS-1
  localparam int CNT_W    = 5;                   // bit step 0 .. VALUE_W-1

  localparam logic [CMD_W-1:0] CMD_SDEC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UDEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LHEX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UHEX = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [16*CHAR_W-1:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [16*CHAR_W-1:0] UPPER_DIGITS = "0123456789ABCDEF";

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // One correction pass of the double-dabble step: add 3 to every digit >= 5.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    logic [DIGIT_W-1:0] d;
    res = bcd;
    for (int i = 0; i < NDIGITS; i++) begin
      d = bcd[i*DIGIT_W +: DIGIT_W];
      if (d >= 4'd5) begin
        res[i*DIGIT_W +: DIGIT_W] = d + 4'd3;
      end
    end
    return res;
  endfunction

  // Index of the most significant non-zero digit; zero when all digits are zero.
  function automatic logic [IDX_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NDIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [16*CHAR_W-1:0] tab;
    logic [DIGIT_W-1:0]   pos;
    tab = upper ? UPPER_DIGITS : LOWER_DIGITS;
    pos = 4'd15 - d;
    return tab[{pos, 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== design/integer_to_ascii_converter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_converter : 32-bit value to ASCII text, one character a transfer
// Formats a value as signed decimal, unsigned decimal or hex, most significant
// character first, with out_last on the final character.
// ----------------------------------------------------------------------------
// One number is in flight at a time: in_ready is high only while the sequencer
// is idle. A decimal item is accepted, then runs through a shared shift-and-add-3
// (double dabble) unit, one value bit a cycle, and the leading digit search, then
// gives one character a cycle while the sink does not stall (a '-' for a
// negative signed value, then up to 10 digits). A hex item skips the conversion
// and gives up to 8 digits. Characters leave through a single output register,
// so the next number is accepted while the final character still waits for
// out_ready. Zero gives "0" in every format; 0x80000000 as signed decimal gives
// "-2147483648". Nothing is kept from one number to the next.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [itoa_pkg::CMD_W-1:0]       in_cmd,
  input  logic [itoa_pkg::VALUE_W-1:0]     in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]      out_text_char,
  output logic                             out_last
);

  itoa_pkg::state_t state_r, state_nxt;

  // Digit store: BCD digits after conversion, or the hex nibbles directly.
  logic [itoa_pkg::BCD_W-1:0]   digits_r, digits_nxt;
  logic [itoa_pkg::VALUE_W-1:0] bin_r, bin_nxt;        // bits still to shift in
  logic [itoa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;        // conversion step
  logic [itoa_pkg::IDX_W-1:0]   idx_r, idx_nxt;        // digit being emitted
  logic                         neg_r, neg_nxt;
  logic                         upper_r, upper_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [itoa_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_xfer;
  logic                         out_load;   // output register free for a new character
  logic                         in_neg;
  logic [itoa_pkg::VALUE_W-1:0] in_mag;
  logic [itoa_pkg::BCD_W-1:0]   bcd_adj;
  logic [itoa_pkg::DIGIT_W-1:0] cur_digit;

  assign in_ready      = (state_r == itoa_pkg::ST_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_load      = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

  // Two's complement magnitude for a negative signed value; the most negative
  // value maps onto itself, which is its correct unsigned magnitude.
  assign in_neg = (in_cmd == itoa_pkg::CMD_SDEC) && in_value[itoa_pkg::VALUE_W-1];
  assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

  assign bcd_adj   = itoa_pkg::bcd_adjust(digits_r);
  assign cur_digit = digits_r[idx_r * itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W];

  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = digits_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r && !out_ready;   // drop the character once transferred
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = in_neg;
          upper_nxt = (in_cmd == itoa_pkg::CMD_UHEX);
          cnt_nxt   = '0;
          if (in_cmd == itoa_pkg::CMD_LHEX || in_cmd == itoa_pkg::CMD_UHEX) begin
            // Hex nibbles are the digits already
            digits_nxt = {{(itoa_pkg::BCD_W - itoa_pkg::VALUE_W){1'b0}}, in_value};
            state_nxt  = itoa_pkg::ST_SCAN;
          end else begin
            digits_nxt = '0;
            bin_nxt    = in_mag;
            state_nxt  = itoa_pkg::ST_CONV;
          end
        end
      end

      itoa_pkg::ST_CONV: begin
        // Correct each digit, then shift the next value bit into the BCD chain
        digits_nxt = {bcd_adj[itoa_pkg::BCD_W-2:0], bin_r[itoa_pkg::VALUE_W-1]};
        bin_nxt    = {bin_r[itoa_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == itoa_pkg::CNT_W'(itoa_pkg::VALUE_W - 1)) begin
          state_nxt = itoa_pkg::ST_SCAN;
        end
      end

      itoa_pkg::ST_SCAN: begin
        // Skip leading zeros; a zero value still emits its single digit
        idx_nxt   = itoa_pkg::msd_index(digits_r);
        state_nxt = neg_r ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
      end

      itoa_pkg::ST_SIGN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = itoa_pkg::ST_EMIT;
        end
      end

      itoa_pkg::ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::digit_char(cur_digit, upper_r);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = itoa_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end

      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers: no reset needed
  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    bin_r      <= bin_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== design/itoa_checker.sv =====
// ----------------------------------------------------------------------------
// itoa_checker : port-level checks of the integer to ASCII converter
// Watches the top level's ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module itoa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [itoa_pkg::CHAR_W-1:0]  out_text_char,
  input logic                         out_last
);

  // Hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char) && $stable(out_last))
    else $error("stalled output character changed");

  // One number at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a number is in progress");

  // Only digits, hex letters and the minus sign appear
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char >= 8'h30 && out_text_char <= 8'h39) ||
                  (out_text_char >= 8'h41 && out_text_char <= 8'h46) ||
                  (out_text_char >= 8'h61 && out_text_char <= 8'h66) ||
                  out_text_char == itoa_pkg::CHAR_MINUS)
    else $error("character outside the number alphabet");

  // A sign is always followed by digits
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_char == itoa_pkg::CHAR_MINUS |-> !out_last)
    else $error("minus sign marked as last character");

endmodule

bind integer_to_ascii_converter itoa_checker u_itoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_text_char (out_text_char),
  .out_last      (out_last)
);
